// ===== design/osuf_pkg.sv =====
// Package for the overstrike/underline filter: field widths, character codes,
// payload structs and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package osuf_pkg;

	// Defaults and fixed widths
	localparam int LINE_LEN_DEF = 32;
	localparam int CNT_W        = 6;
	localparam int BYTE_W       = 8;
	localparam int MODE_W       = 2;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_NONE  = 8'h00;

	// Underline modes; any other code means no underlining
	localparam logic [MODE_W-1:0] MODE_DASH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PASS = 2'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
		logic              overflow;
	} out_item_t;

	// Source of the byte loaded into the output register
	typedef enum logic [2:0] {
		SEL_EMIT,
		SEL_NL,
		SEL_MARK,
		SEL_UNDER,
		SEL_BS
	} out_sel_t;

	typedef struct packed {
		logic     accept;
		logic     load;
		out_sel_t sel;
		logic     last;
		logic     rd_start;
		logic     rd_adv;
		logic     line_done;
	} dp_cmd_t;

	typedef struct packed {
		logic             slot_free;
		logic             in_eoi;
		logic             in_nl;
		logic             in_bs;
		logic             held_nz;
		logic             held_under;
		logic             mode_pass;
		logic             trim_zero;
		logic             row_end;
		logic [CNT_W-1:0] mark_count;
		logic [CNT_W-1:0] trim_len;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/osuf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module osuf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/osuf_dp.sv =====
// Datapath of the overstrike/underline filter: held character, mark row RAM,
// mark counters, row read pointer and the output register.
// Depends on osuf_pkg and osuf_ram.
`timescale 1ns / 1ps
`default_nettype none

module osuf_dp #(
	parameter int LINE_LEN = osuf_pkg::LINE_LEN_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [osuf_pkg::MODE_W-1:0]  cfg_wr_data,
	input  wire osuf_pkg::in_item_t           item,
	input  wire osuf_pkg::dp_cmd_t            cmd,
	output osuf_pkg::dp_stat_t                stat,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output osuf_pkg::out_item_t               res
);

	localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
	localparam logic [osuf_pkg::CNT_W-1:0] LEN_C = osuf_pkg::CNT_W'(LINE_LEN);

	logic [osuf_pkg::MODE_W-1:0] mode_q;
	logic [osuf_pkg::BYTE_W-1:0] held_q;
	logic [osuf_pkg::BYTE_W-1:0] emit_q;
	logic                        dash_q;
	logic [osuf_pkg::CNT_W-1:0]  count_q;
	logic [osuf_pkg::CNT_W-1:0]  trim_q;
	logic [osuf_pkg::CNT_W-1:0]  rd_idx_q;
	logic [osuf_pkg::CNT_W-1:0]  rd_idx_d;
	logic                        out_valid_q;
	osuf_pkg::out_item_t         out_q;
	osuf_pkg::out_item_t         out_d;
	logic                        mode_dash;
	logic                        row_full;
	logic                        mark_we;
	logic                        mark_rdata;

	assign mode_dash = (mode_q == osuf_pkg::MODE_DASH);
	assign row_full  = (count_q >= LEN_C);
	assign mark_we   = cmd.load && (cmd.sel == osuf_pkg::SEL_EMIT) && mode_dash && !row_full;

	// Row read pointer; the RAM reads the next index so data lines up with rd_idx_q
	always_comb begin
		rd_idx_d = rd_idx_q;
		if (cmd.rd_start) begin
			rd_idx_d = '0;
		end else if (cmd.rd_adv) begin
			rd_idx_d = rd_idx_q + osuf_pkg::CNT_W'(1);
		end
	end

	osuf_ram #(
		.WIDTH(1),
		.DEPTH(LINE_LEN)
	) u_row (
		.clk  (clk),
		.we   (mark_we),
		.waddr(count_q[AW-1:0]),
		.wdata(dash_q),
		.raddr(rd_idx_d[AW-1:0]),
		.rdata(mark_rdata)
	);

	// Result selection
	always_comb begin
		out_d.last     = cmd.last;
		out_d.overflow = 1'b0;
		case (cmd.sel)
			osuf_pkg::SEL_EMIT: begin
				out_d.out_byte = emit_q;
				out_d.overflow = mode_dash && row_full;
			end
			osuf_pkg::SEL_NL:    out_d.out_byte = osuf_pkg::CH_NL;
			osuf_pkg::SEL_MARK:  out_d.out_byte = mark_rdata ? osuf_pkg::CH_DASH
			                                                 : osuf_pkg::CH_SPACE;
			osuf_pkg::SEL_UNDER: out_d.out_byte = osuf_pkg::CH_UNDER;
			osuf_pkg::SEL_BS:    out_d.out_byte = osuf_pkg::CH_BS;
			default:             out_d.out_byte = osuf_pkg::CH_NL;
		endcase
	end

	// Status to controller
	always_comb begin
		stat.slot_free  = !out_valid_q || !res_stall;
		stat.in_eoi     = item.end_of_input;
		stat.in_nl      = (item.in_byte == osuf_pkg::CH_NL);
		stat.in_bs      = (item.in_byte == osuf_pkg::CH_BS);
		stat.held_nz    = (held_q != osuf_pkg::CH_NONE);
		stat.held_under = (held_q == osuf_pkg::CH_UNDER);
		stat.mode_pass  = (mode_q == osuf_pkg::MODE_PASS);
		stat.trim_zero  = (trim_q == '0);
		stat.row_end    = ((rd_idx_q + osuf_pkg::CNT_W'(1)) == trim_q);
		stat.mark_count = count_q;
		stat.trim_len   = trim_q;
	end

	// Control state: mode, held char, marks, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= osuf_pkg::MODE_DASH;
			held_q      <= osuf_pkg::CH_NONE;
			dash_q      <= 1'b0;
			count_q     <= '0;
			trim_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			rd_idx_q <= rd_idx_d;

			// Item accept: update held char, arm dash on underscore-backspace in dash mode
			if (cmd.accept) begin
				if (item.end_of_input || stat.in_nl || stat.in_bs) begin
					held_q <= osuf_pkg::CH_NONE;
				end else begin
					held_q <= item.in_byte;
				end
				if (!item.end_of_input && stat.in_bs && stat.held_under && mode_dash) begin
					dash_q <= 1'b1;
				end
			end

			// Character emit appends a mark in dash mode unless the row is full
			if (cmd.load && (cmd.sel == osuf_pkg::SEL_EMIT) && mode_dash) begin
				if (!row_full) begin
					count_q <= count_q + osuf_pkg::CNT_W'(1);
					if (dash_q) begin
						trim_q <= count_q + osuf_pkg::CNT_W'(1);
					end
				end
				dash_q <= 1'b0;
			end

			// End of line empties the row
			if (cmd.line_done) begin
				count_q <= '0;
				trim_q  <= '0;
				dash_q  <= 1'b0;
			end

			// Output register valid
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			emit_q <= held_q;
		end
		if (cmd.load) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

// ===== design/osuf_ctrl.sv =====
// Controller of the overstrike/underline filter: sequences the results of
// one input transaction. Depends on osuf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osuf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire osuf_pkg::dp_stat_t stat,
	output osuf_pkg::dp_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT,
		S_NL1,
		S_ROW,
		S_NL2,
		S_UNDER,
		S_BS
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   then_end_q;
	logic   then_end_d;

	// Next state and datapath commands
	always_comb begin
		state_d    = state_q;
		then_end_d = then_end_q;
		cmd        = '0;
		cmd.sel    = osuf_pkg::SEL_NL;
		item_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (stat.in_eoi) begin
						then_end_d = 1'b1;
						state_d    = stat.held_nz ? S_EMIT : S_IDLE;
					end else if (stat.in_nl) begin
						then_end_d = 1'b1;
						state_d    = stat.held_nz ? S_EMIT : S_NL1;
					end else if (stat.in_bs) begin
						state_d = (stat.held_under && stat.mode_pass) ? S_UNDER : S_IDLE;
					end else begin
						then_end_d = 1'b0;
						state_d    = stat.held_nz ? S_EMIT : S_IDLE;
					end
				end
			end
			S_EMIT: begin
				cmd.sel = osuf_pkg::SEL_EMIT;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.last = !then_end_q;
					state_d  = then_end_q ? S_NL1 : S_IDLE;
				end
			end
			S_NL1: begin
				cmd.sel = osuf_pkg::SEL_NL;
				if (stat.slot_free) begin
					cmd.load      = 1'b1;
					cmd.last      = stat.trim_zero;
					cmd.rd_start  = 1'b1;
					cmd.line_done = stat.trim_zero;
					state_d       = stat.trim_zero ? S_IDLE : S_ROW;
				end
			end
			S_ROW: begin
				cmd.sel = osuf_pkg::SEL_MARK;
				if (stat.slot_free) begin
					cmd.load   = 1'b1;
					cmd.rd_adv = !stat.row_end;
					state_d    = stat.row_end ? S_NL2 : S_ROW;
				end
			end
			S_NL2: begin
				cmd.sel = osuf_pkg::SEL_NL;
				if (stat.slot_free) begin
					cmd.load      = 1'b1;
					cmd.last      = 1'b1;
					cmd.line_done = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_UNDER: begin
				cmd.sel = osuf_pkg::SEL_UNDER;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					state_d  = S_BS;
				end
			end
			S_BS: begin
				cmd.sel = osuf_pkg::SEL_BS;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			then_end_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			then_end_q <= then_end_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/overstrike_underline_filter_core.sv =====
// Top level of the overstrike/underline filter: controller, datapath, checks.
// Depends on osuf_pkg, osuf_ctrl, osuf_dp (and osuf_ram through it).
//
// Usage:
//  Input channel item_valid / item_stall / item carries one text byte or an
//  end-of-input mark per transaction. Output channel res_valid / res_stall /
//  res carries one result byte per transaction; last marks the final result
//  of an input transaction, overflow marks a char whose mark did not fit in the row.
//  cfg_wr_en / cfg_wr_data write the underline mode; write only while idle.
//  Sequence: an item is taken while idle, then its results are loaded in
//  order. A plain byte gives the held char, if any; a backspace gives none,
//  or "_" and BS if it passes them on. A newline gives the held char if any
//  and a newline, plus R marks and a newline when R marks remain after
//  trimming (R <= LINE_LEN); an end item is the same when a char is held,
//  else none. One result loads per cycle unless a stall holds the register.
//  Reset (arst_n low) clears the held char, mark count and mode (dash mode);
//  the mark row RAM is not cleared, entries past the count are never read.
//  When the receiver stalls, the result holds in the output register and the
//  controller waits; item_stall stays high until an item's results are loaded.
`timescale 1ns / 1ps
`default_nettype none

module overstrike_underline_filter_core #(
	parameter int LINE_LEN = osuf_pkg::LINE_LEN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [osuf_pkg::MODE_W-1:0] cfg_wr_data,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire osuf_pkg::in_item_t          item,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output osuf_pkg::out_item_t              res
);

	osuf_pkg::dp_cmd_t  cmd;
	osuf_pkg::dp_stat_t stat;

	osuf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	osuf_dp #(
		.LINE_LEN(LINE_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item),
		.cmd        (cmd),
		.stat       (stat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	// Mark count never exceeds the row length
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.mark_count <= osuf_pkg::CNT_W'(LINE_LEN))
	else $error("mark count beyond row length");

	// Trimmed length never exceeds the mark count
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.trim_len <= stat.mark_count)
	else $error("trimmed row longer than mark count");

	// A result is only loaded when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> stat.slot_free)
	else $error("output register overwritten while stalled");

	// No input transaction is taken while results are being loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.accept)
	else $error("item accepted during result sequence");

endmodule

`default_nettype wire
